/* src/apcr_pkg.sv */
// Shared types, codes and helpers for the box pair collision resolver.
// Used by every module of the block and by its checker.
package apcr_pkg;

  localparam logic CMD_STORE = 1'b0;
  localparam logic CMD_TEST  = 1'b1;

  localparam logic [1:0] AXIS_NONE = 2'd0;
  localparam logic [1:0] AXIS_X    = 2'd1;
  localparam logic [1:0] AXIS_Y    = 2'd2;
  localparam logic [1:0] AXIS_Z    = 2'd3;

  typedef struct packed {
    logic               cmd;
    logic signed [31:0] min_x;
    logic signed [31:0] max_x;
    logic signed [31:0] min_y;
    logic signed [31:0] max_y;
    logic signed [31:0] min_z;
    logic signed [31:0] max_z;
    logic signed [31:0] center_x;
    logic signed [31:0] center_y;
    logic signed [31:0] center_z;
    logic               is_fixed;
  } box_t;

  typedef struct packed {
    logic [1:0]         hit_axis;
    logic signed [31:0] first_dx;
    logic signed [31:0] first_dy;
    logic signed [31:0] first_dz;
    logic signed [31:0] second_dx;
    logic signed [31:0] second_dy;
    logic signed [31:0] second_dz;
  } result_t;

  typedef struct packed {
    logic               hit;
    logic [2:0]         ctr_gt;
    logic               held_fixed;
    logic               box_fixed;
    logic signed [31:0] d_ax;
    logic signed [31:0] d_ay;
    logic signed [31:0] d_az;
    logic signed [31:0] d_bx;
    logic signed [31:0] d_by;
    logic signed [31:0] d_bz;
  } test_t;

  function automatic logic signed [31:0] sat_sub(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    logic signed [32:0] d;
    d = {a[31], a} - {b[31], b};
    if (d[32] != d[31]) begin
      sat_sub = d[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end else begin
      sat_sub = d[31:0];
    end
  endfunction

endpackage

/* src/apcr_front.sv */
// Front end: accepts box items, holds the first box, forms overlap and edge differences.
// Depends on apcr_pkg.
module apcr_front import apcr_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  logic  full,
  input  box_t  box,
  output logic  enq_valid,
  output test_t enq_data
);

  logic signed [31:0] held_min    [3];
  logic signed [31:0] held_max    [3];
  logic signed [31:0] held_center [3];
  logic               held_fixed;

  logic signed [31:0] b_min [3];
  logic signed [31:0] b_max [3];
  logic signed [31:0] b_ctr [3];
  logic signed [31:0] d_a   [3];
  logic signed [31:0] d_b   [3];
  logic [2:0]         ovl;
  logic [2:0]         gt;
  logic               accept;

  assign accept = push && !full;

  always_comb begin
    b_min[0] = box.min_x;
    b_max[0] = box.max_x;
    b_min[1] = box.min_y;
    b_max[1] = box.max_y;
    b_min[2] = box.min_z;
    b_max[2] = box.max_z;
    b_ctr[0] = box.center_x;
    b_ctr[1] = box.center_y;
    b_ctr[2] = box.center_z;
    for (int k = 0; k < 3; k++) begin
      ovl[k] = (held_max[k] >= b_min[k]) && (b_max[k] >= held_min[k]);
      gt[k]  = held_center[k] > b_ctr[k];
      d_a[k] = sat_sub(held_max[k], b_min[k]);
      d_b[k] = sat_sub(b_max[k], held_min[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < 3; k++) begin
        held_min[k]    <= '0;
        held_max[k]    <= '0;
        held_center[k] <= '0;
      end
      held_fixed <= 1'b0;
    end else if (accept && box.cmd == CMD_STORE) begin
      for (int k = 0; k < 3; k++) begin
        held_min[k]    <= b_min[k];
        held_max[k]    <= b_max[k];
        held_center[k] <= b_ctr[k];
      end
      held_fixed <= box.is_fixed;
    end
  end

  assign enq_valid = accept && box.cmd == CMD_TEST;

  always_comb begin
    enq_data.hit        = &ovl;
    enq_data.ctr_gt     = gt;
    enq_data.held_fixed = held_fixed;
    enq_data.box_fixed  = box.is_fixed;
    enq_data.d_ax       = d_a[0];
    enq_data.d_ay       = d_a[1];
    enq_data.d_az       = d_a[2];
    enq_data.d_bx       = d_b[0];
    enq_data.d_by       = d_b[1];
    enq_data.d_bz       = d_b[2];
  end

endmodule

/* src/apcr_queue.sv */
// Short register queue between the front end and the resolve pipeline.
// Depends on apcr_pkg.
module apcr_queue import apcr_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  enq_valid,
  input  test_t enq_data,
  output logic  full,
  output logic  deq_valid,
  input  logic  deq_ready,
  output test_t deq_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  test_t            mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             wr;
  logic             rd;

  assign full      = count == CNT_W'(DEPTH);
  assign deq_valid = count != '0;
  assign deq_data  = mem[rd_ptr];
  assign wr        = enq_valid && !full;
  assign rd        = deq_ready && deq_valid;

  function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
    bump = (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wr_ptr] <= enq_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (rd) begin
        rd_ptr <= bump(rd_ptr);
      end
      case ({wr, rd})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

/* src/apcr_back.sv */
// Resolve pipeline: penetration minimum, axis choice, push split, result register.
// Depends on apcr_pkg.
module apcr_back import apcr_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    deq_valid,
  output logic    deq_ready,
  input  test_t   deq_data,
  output logic    empty,
  input  logic    pop,
  output result_t result
);

  logic               s1_valid;
  logic signed [31:0] s1_pen [3];
  logic               s1_hit;
  logic [2:0]         s1_gt;
  logic               s1_hf;
  logic               s1_bf;

  logic               s2_valid;
  logic [1:0]         s2_axis;
  logic signed [31:0] s2_mv;
  logic               s2_hf;
  logic               s2_bf;

  logic               out_valid;

  logic               s1_ready;
  logic               s2_ready;
  logic               out_ready;

  logic signed [31:0] da [3];
  logic signed [31:0] db [3];
  logic [1:0]         axis_sel;
  logic signed [31:0] mv_sel;
  logic signed [31:0] half;
  logic signed [31:0] fv;
  logic signed [31:0] sv;

  assign out_ready = !out_valid || pop;
  assign s2_ready  = !s2_valid || out_ready;
  assign s1_ready  = !s1_valid || s2_ready;
  assign deq_ready = s1_ready;
  assign empty     = !out_valid;

  always_comb begin
    da[0] = deq_data.d_ax;
    da[1] = deq_data.d_ay;
    da[2] = deq_data.d_az;
    db[0] = deq_data.d_bx;
    db[1] = deq_data.d_by;
    db[2] = deq_data.d_bz;
  end

  always_comb begin
    axis_sel = AXIS_NONE;
    mv_sel   = '0;
    if (s1_hit) begin
      if (s1_pen[1] <= s1_pen[0] && s1_pen[1] <= s1_pen[2]) begin
        axis_sel = AXIS_Y;
        mv_sel   = s1_gt[1] ? s1_pen[1] : -s1_pen[1];
      end else if (s1_pen[0] <= s1_pen[1] && s1_pen[0] <= s1_pen[2]) begin
        axis_sel = AXIS_X;
        mv_sel   = s1_gt[0] ? s1_pen[0] : -s1_pen[0];
      end else begin
        axis_sel = AXIS_Z;
        mv_sel   = s1_gt[2] ? s1_pen[2] : -s1_pen[2];
      end
    end
  end

  always_comb begin
    half = s2_mv >>> 1;
    case ({s2_hf, s2_bf})
      2'b01: begin
        fv = s2_mv;
        sv = '0;
      end
      2'b10: begin
        fv = '0;
        sv = -s2_mv;
      end
      2'b00: begin
        fv = half;
        sv = -half;
      end
      default: begin
        fv = '0;
        sv = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid <= deq_valid;
      end
      if (s2_ready) begin
        s2_valid <= s1_valid;
      end
      if (out_ready) begin
        out_valid <= s2_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && deq_valid) begin
      for (int k = 0; k < 3; k++) begin
        s1_pen[k] <= (da[k] < db[k]) ? da[k] : db[k];
      end
      s1_hit <= deq_data.hit;
      s1_gt  <= deq_data.ctr_gt;
      s1_hf  <= deq_data.held_fixed;
      s1_bf  <= deq_data.box_fixed;
    end
    if (s2_ready && s1_valid) begin
      s2_axis <= axis_sel;
      s2_mv   <= mv_sel;
      s2_hf   <= s1_hf;
      s2_bf   <= s1_bf;
    end
    if (out_ready && s2_valid) begin
      result.hit_axis  <= s2_axis;
      result.first_dx  <= (s2_axis == AXIS_X) ? fv : '0;
      result.first_dy  <= (s2_axis == AXIS_Y) ? fv : '0;
      result.first_dz  <= (s2_axis == AXIS_Z) ? fv : '0;
      result.second_dx <= (s2_axis == AXIS_X) ? sv : '0;
      result.second_dy <= (s2_axis == AXIS_Y) ? sv : '0;
      result.second_dz <= (s2_axis == AXIS_Z) ? sv : '0;
    end
  end

endmodule

/* src/aabb_pair_collision_resolve.sv */
// Top level of the box pair collision resolver.
// Depends on apcr_pkg, apcr_front, apcr_queue and apcr_back.
//
// Input channel: box items enter through push/full. A store command loads
// the first box and yields no result; a test command checks the given box
// against the stored one and yields exactly one result.
// Result channel: empty/pop. The oldest result sits on result while empty
// is low and leaves at an edge with pop high.
// Throughput: one item per cycle while full stays low. A test item passes
// through the test queue, then the penetration stage, the axis stage and the
// result register of the resolve pipeline before its result shows.
// A store item takes effect at once for the next test item.
// When pop stays low the pipeline stages fill, then the test queue
// (QUEUE_DEPTH entries); full rises only when the queue is full.
// Reset clears the stored box to all zero and moving, and empties the queue
// and the pipeline.
module aabb_pair_collision_resolve import apcr_pkg::*; #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  output logic    full,
  input  box_t    box,
  output logic    empty,
  input  logic    pop,
  output result_t result
);

  logic  enq_valid;
  test_t enq_data;
  logic  deq_valid;
  logic  deq_ready;
  test_t deq_data;

  apcr_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .box       (box),
    .enq_valid (enq_valid),
    .enq_data  (enq_data)
  );

  apcr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .enq_valid (enq_valid),
    .enq_data  (enq_data),
    .full      (full),
    .deq_valid (deq_valid),
    .deq_ready (deq_ready),
    .deq_data  (deq_data)
  );

  apcr_back u_back (
    .clk       (clk),
    .rst       (rst),
    .deq_valid (deq_valid),
    .deq_ready (deq_ready),
    .deq_data  (deq_data),
    .empty     (empty),
    .pop       (pop),
    .result    (result)
  );

endmodule

/* src/apcr_checker.sv */
// Port-level checks for the box pair collision resolver, bound to its top level.
// Depends on apcr_pkg.
module apcr_checker import apcr_pkg::*; (
  input logic    clk,
  input logic    rst,
  input logic    push,
  input logic    full,
  input box_t    box,
  input logic    empty,
  input logic    pop,
  input result_t result
);

  a_reset_clear: assert property (@(posedge clk) rst |=> empty && !full)
    else $error("queue not clear after reset");

  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty && $stable(result))
    else $error("waiting result changed");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    !empty && result.hit_axis == AXIS_NONE |->
      result.first_dx == 0 && result.first_dy == 0 && result.first_dz == 0 &&
      result.second_dx == 0 && result.second_dy == 0 && result.second_dz == 0)
    else $error("nonzero correction without a hit");

  a_x_only: assert property (@(posedge clk) disable iff (rst)
    !empty && result.hit_axis == AXIS_X |->
      result.first_dy == 0 && result.first_dz == 0 &&
      result.second_dy == 0 && result.second_dz == 0)
    else $error("correction off the chosen axis");

endmodule

bind aabb_pair_collision_resolve apcr_checker u_apcr_checker (.*);

/* tb/aabb_pair_collision_resolve_test.sv */
// Self-checking bench for aabb_pair_collision_resolve: a directed table, then random box pairs.
// Fields are checked against a typed row's result or a built-in resolver with its own held box.
// Depends on apcr_pkg and the aabb_pair_collision_resolve RTL.
module aabb_pair_collision_resolve_test import apcr_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int HALF_PERIOD = 5;
  localparam int RESET_CYCLES = 11;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_ITEMS = 450;
  localparam int TAIL_CYCLES = 8;
  localparam int HOLD_AFTER = 150;
  localparam int HOLD_CYCLES = 100;
  localparam int MAX_Q = 32'h7fff_ffff;
  localparam int MIN_Q = -2147483647 - 1;
  localparam int ONE_Q = 32'h0001_0000;

  typedef struct {
    box_t    item;
    bit      typed;
    result_t want;
  } plan_row_t;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    push = 1'b0;
  logic    full;
  box_t    box = '0;
  logic    empty;
  logic    pop = 1'b0;
  result_t result;

  logic signed [31:0] held_lo[3] = '{0, 0, 0};
  logic signed [31:0] held_hi[3] = '{0, 0, 0};
  logic signed [31:0] held_mid[3] = '{0, 0, 0};
  logic               held_static = 1'b0;

  result_t   pending_fixes[$];
  plan_row_t plan[$];
  int        push_idle_pct = 0;
  int        pop_idle_pct = 0;
  int        mismatches = 0;
  int        results_seen = 0;
  int        hold_left = 0;
  bit        hold_done = 1'b0;
  int        cycle_count = 0;
  result_t   want;

  aabb_pair_collision_resolve i_dut (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .full  (full),
    .box   (box),
    .empty (empty),
    .pop   (pop),
    .result(result)
  );

  always #HALF_PERIOD clk = ~clk;

  always @(posedge clk) cycle_count <= cycle_count + 1;

  function automatic box_t mk_box(logic cmd, logic fixed, int lx, int hx, int ly, int hy,
                                  int lz, int hz, int cx, int cy, int cz);
    box_t b;
    b.cmd = cmd;
    b.is_fixed = fixed;
    b.min_x = lx;
    b.max_x = hx;
    b.min_y = ly;
    b.max_y = hy;
    b.min_z = lz;
    b.max_z = hz;
    b.center_x = cx;
    b.center_y = cy;
    b.center_z = cz;
    return b;
  endfunction

  function automatic result_t mk_res(logic [1:0] axis, int fdx, int fdy, int fdz,
                                     int sdx, int sdy, int sdz);
    result_t r;
    r.hit_axis = axis;
    r.first_dx = fdx;
    r.first_dy = fdy;
    r.first_dz = fdz;
    r.second_dx = sdx;
    r.second_dy = sdy;
    r.second_dz = sdz;
    return r;
  endfunction

  function automatic void split_box(input box_t b, output logic signed [31:0] lo[3],
                                    output logic signed [31:0] hi[3],
                                    output logic signed [31:0] ctr[3]);
    lo[0] = b.min_x;
    hi[0] = b.max_x;
    lo[1] = b.min_y;
    hi[1] = b.max_y;
    lo[2] = b.min_z;
    hi[2] = b.max_z;
    ctr[0] = b.center_x;
    ctr[1] = b.center_y;
    ctr[2] = b.center_z;
  endfunction

  function automatic longint clamp32(longint v);
    if (v > longint'(MAX_Q)) return longint'(MAX_Q);
    if (v < longint'(MIN_Q)) return longint'(MIN_Q);
    return v;
  endfunction

  function automatic result_t resolve_pair(box_t b);
    logic signed [31:0] lo[3], hi[3], ctr[3];
    longint depth[3];
    longint d_near, d_far, push_amt, first_mv, second_mv;
    bit overlap;
    int idx;
    result_t r;
    split_box(b, lo, hi, ctr);
    r = '0;
    overlap = 1'b1;
    for (int k = 0; k < 3; k++) begin
      if (held_hi[k] < lo[k] || hi[k] < held_lo[k]) overlap = 1'b0;
      d_near = clamp32(longint'(held_hi[k]) - longint'(lo[k]));
      d_far = clamp32(longint'(hi[k]) - longint'(held_lo[k]));
      depth[k] = (d_near < d_far) ? d_near : d_far;
    end
    if (!overlap) return r;
    if (depth[1] <= depth[0] && depth[1] <= depth[2]) idx = 1;
    else if (depth[0] <= depth[1] && depth[0] <= depth[2]) idx = 0;
    else idx = 2;
    push_amt = (held_mid[idx] > ctr[idx]) ? depth[idx] : -depth[idx];
    first_mv = 0;
    second_mv = 0;
    if (!held_static && b.is_fixed) begin
      first_mv = push_amt;
    end else if (held_static && !b.is_fixed) begin
      second_mv = -push_amt;
    end else if (!held_static && !b.is_fixed) begin
      first_mv = push_amt >>> 1;
      second_mv = -first_mv;
    end
    case (idx)
      0: begin
        r.hit_axis = AXIS_X;
        r.first_dx = first_mv[31:0];
        r.second_dx = second_mv[31:0];
      end
      1: begin
        r.hit_axis = AXIS_Y;
        r.first_dy = first_mv[31:0];
        r.second_dy = second_mv[31:0];
      end
      default: begin
        r.hit_axis = AXIS_Z;
        r.first_dz = first_mv[31:0];
        r.second_dz = second_mv[31:0];
      end
    endcase
    return r;
  endfunction

  function automatic int edge_word();
    case ($urandom_range(3))
      0: return MIN_Q;
      1: return MAX_Q;
      2: return 0;
      default: return -1;
    endcase
  endfunction

  function automatic box_t rand_box();
    int lo[3], hi[3], ctr[3];
    int unit, mid, tmp, mode;
    logic cmd;
    mode = $urandom_range(9);
    cmd = ($urandom_range(99) < 30) ? CMD_STORE : CMD_TEST;
    for (int k = 0; k < 3; k++) begin
      case (mode)
        0: begin
          lo[k] = $urandom;
          hi[k] = $urandom;
          ctr[k] = $urandom;
        end
        1: begin
          lo[k] = edge_word();
          hi[k] = edge_word();
          ctr[k] = edge_word();
        end
        default: begin
          unit = $urandom_range(1) ? 1 : ONE_Q;
          if (cmd == CMD_TEST && $urandom_range(3) != 0) begin
            mid = held_mid[k] + (int'($urandom_range(16)) - 8) * unit;
          end else begin
            mid = (int'($urandom_range(64)) - 32) * unit;
          end
          lo[k] = mid - int'($urandom_range(8)) * unit;
          hi[k] = mid + int'($urandom_range(8)) * unit;
          ctr[k] = (cmd == CMD_TEST && $urandom_range(3) == 0) ? int'(held_mid[k]) : mid;
          if ($urandom_range(15) == 0) begin
            tmp = lo[k];
            lo[k] = hi[k];
            hi[k] = tmp;
          end
        end
      endcase
    end
    return mk_box(cmd, $urandom_range(99) < 30, lo[0], hi[0], lo[1], hi[1], lo[2], hi[2],
                  ctr[0], ctr[1], ctr[2]);
  endfunction

  task automatic add_row(box_t b, bit typed = 1'b0, result_t r = '0);
    plan_row_t row;
    row = '{b, typed, r};
    plan.insert(plan.size(), row);
  endtask

  task automatic send_box(box_t b, bit typed = 1'b0, result_t r = '0);
    while ($urandom_range(99) < push_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    box <= b;
    @(posedge clk);
    while (full) @(posedge clk);
    if (b.cmd == CMD_STORE) begin
      split_box(b, held_lo, held_hi, held_mid);
      held_static = b.is_fixed;
    end else begin
      pending_fixes.insert(pending_fixes.size(), typed ? r : resolve_pair(b));
    end
  endtask

  task automatic drain_results();
    push <= 1'b0;
    @(posedge clk);
    while (pending_fixes.size() != 0) @(posedge clk);
  endtask

  task automatic compare_field(string name, logic [31:0] exp_val, logic [31:0] got_val);
    if (exp_val !== got_val) begin
      $error("%s: expected 0x%08h, actual 0x%08h", name, exp_val, got_val);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (pending_fixes.size() == 0) begin
          $error("unexpected result transfer: %p", result);
          mismatches++;
        end else begin
          want = pending_fixes.pop_front();
          compare_field("hit_axis", want.hit_axis, result.hit_axis);
          compare_field("first_dx", want.first_dx, result.first_dx);
          compare_field("first_dy", want.first_dy, result.first_dy);
          compare_field("first_dz", want.first_dz, result.first_dz);
          compare_field("second_dx", want.second_dx, result.second_dx);
          compare_field("second_dy", want.second_dy, result.second_dy);
          compare_field("second_dz", want.second_dz, result.second_dz);
        end
        results_seen++;
      end
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        pop <= 1'b0;
      end else if (!hold_done && results_seen >= HOLD_AFTER) begin
        hold_left <= HOLD_CYCLES;
        hold_done <= 1'b1;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(99) >= pop_idle_pct);
      end
    end
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    // reset box is all zero and moving
    add_row(mk_box(CMD_TEST, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, mk_res(AXIS_Y, 0, 0, 0, 0, 0, 0));
    add_row(mk_box(CMD_TEST, 0, 1, 1, 0, 0, 0, 0, 0, 0, 0), 1, mk_res(AXIS_NONE, 0, 0, 0, 0, 0, 0));
    add_row(mk_box(CMD_STORE, 1, -10, 10, -10, 10, -10, 10, 0, 0, 0));
    add_row(mk_box(CMD_TEST, 1, 5, 20, -100, 100, -100, 100, 0, 0, 0), 1,
            mk_res(AXIS_X, 0, 0, 0, 0, 0, 0));
    add_row(mk_box(CMD_STORE, 0, MIN_Q, MAX_Q, MIN_Q, MAX_Q, MIN_Q, MAX_Q, 0, 0, 0));
    add_row(mk_box(CMD_TEST, 0, MIN_Q, MAX_Q, MIN_Q, MAX_Q, MIN_Q, MAX_Q, 0, 0, 0), 1,
            mk_res(AXIS_Y, 0, 32'hc000_0000, 0, 0, 32'h4000_0000, 0));
    add_row(mk_box(CMD_TEST, 1, MIN_Q, MAX_Q, MIN_Q, MAX_Q, MIN_Q, MAX_Q, 0, 0, 0), 1,
            mk_res(AXIS_Y, 0, MIN_Q + 1, 0, 0, 0, 0));
    add_row(mk_box(CMD_STORE, 1, MIN_Q, MAX_Q, MIN_Q, MAX_Q, MIN_Q, MAX_Q, MIN_Q, MIN_Q, MIN_Q));
    add_row(mk_box(CMD_TEST, 0, MIN_Q, MAX_Q, MIN_Q, MAX_Q, MIN_Q, MAX_Q, 0, 0, 0), 1,
            mk_res(AXIS_Y, 0, 0, 0, 0, MAX_Q, 0));
    add_row(mk_box(CMD_TEST, 0, MIN_Q, MAX_Q, MIN_Q, MAX_Q, MIN_Q, MAX_Q, MAX_Q, MAX_Q, MAX_Q));
    add_row(mk_box(CMD_STORE, 0, 0, 8, 0, 20, 0, 20, 4, 10, 10));
    add_row(mk_box(CMD_TEST, 0, 6, 14, 0, 20, 0, 20, 10, 10, 10));
    add_row(mk_box(CMD_TEST, 0, 0, 8, 0, 20, 17, 30, 4, 10, 10));
    add_row(mk_box(CMD_TEST, 1, -5, 3, 17, 25, 17, 40, 0, 5, 0));
    add_row(mk_box(CMD_TEST, 1, 5, 8, 0, 20, 17, 30, 0, 0, 0));
    add_row(mk_box(CMD_TEST, 0, 3, 8, 0, 20, 0, 20, 0, 10, 10));
    add_row(mk_box(CMD_TEST, 0, 5, 3, 0, 20, 0, 20, 4, 10, 10));
    add_row(mk_box(CMD_TEST, 0, 10, 2, 0, 20, 0, 20, 4, 10, 10));
    add_row(mk_box(CMD_TEST, 0, 8, 12, 0, 20, 0, 20, 4, 10, 10));
    add_row(mk_box(CMD_TEST, 0, 9, 12, 0, 20, 0, 20, 4, 10, 10), 1,
            mk_res(AXIS_NONE, 0, 0, 0, 0, 0, 0));
    add_row(mk_box(CMD_TEST, 0, MIN_Q, MAX_Q, 0, 20, 0, 20, MIN_Q, 10, 10));
    add_row(mk_box(CMD_STORE, 1, -3 * ONE_Q, 5 * ONE_Q, -ONE_Q, ONE_Q, -ONE_Q, ONE_Q, 0, 0, 0));
    add_row(mk_box(CMD_TEST, 0, 4 * ONE_Q, 9 * ONE_Q, -ONE_Q, 2 * ONE_Q, -9 * ONE_Q, 0,
                   7 * ONE_Q, ONE_Q, -ONE_Q));

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) send_box(plan[i].item, plan[i].typed, plan[i].want);
    drain_results();

    for (int phase = 0; phase < 3; phase++) begin
      push_idle_pct = (phase == 0) ? 27 : (phase == 1) ? 48 : 0;
      pop_idle_pct = (phase == 0) ? 48 : (phase == 1) ? 27 : 0;
      for (int n = 0; n < PHASE_ITEMS; n++) send_box(rand_box());
      // hold the sender until the block has handed back everything
      if (phase != 2) drain_results();
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_fixes.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
